@@ hdl/btpf_pkg.sv @@
// ---------------------------------------------------------------------------
// btpf_pkg: shared types and constants of the background tile pixel fetcher
// Holds the command codes, the fetcher phases, the video memory geometry and
// the memory request bundle used by the top level and the video memory.
// ---------------------------------------------------------------------------
package btpf_pkg;

   localparam int VRAM_BYTES  = 8192;
   localparam int VRAM_ADDR_W = 13;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_TAKE    = 2'd2,
      CMD_WRITE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_TILE_ID = 2'd0,
      PH_LOW     = 2'd1,
      PH_HIGH    = 2'd2,
      PH_READY   = 2'd3
   } phase_type;

   // Which fetcher register picks up the memory read data of the read issued with it.
   typedef enum logic [1:0] {
      CAP_NONE = 2'd0,
      CAP_ID   = 2'd1,
      CAP_LOW  = 2'd2,
      CAP_HIGH = 2'd3
   } capture_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TILE_MAP_SELECT    = 1'd0,
      CSR_TILE_DATA_UNSIGNED = 1'd1
   } csr_index_type;

   // Map bases 0x1800 / 0x1C00 share the two top address bits.
   localparam logic [1:0] MAP_BASE_TOP = 2'b11;

   typedef struct packed {
      logic                   en;
      logic                   we;
      logic [VRAM_ADDR_W-1:0] addr;
      logic [7:0]             wdata;
   } vram_req_type;

endpackage

@@ hdl/btpf_vram.sv @@
// ---------------------------------------------------------------------------
// btpf_vram: video memory of the background fetcher
// Single-port synchronous RAM, 8 KiB by 8 bits, read data registered.
// ---------------------------------------------------------------------------
module btpf_vram
   import btpf_pkg::*;
(
   input  logic         clock,
   input  vram_req_type req,
   output logic [7:0]   rd_data
);

   logic [7:0] mem [VRAM_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.en) begin
         if (req.we) begin
            mem[req.addr] <= req.wdata;
         end else begin
            rd_data_ff <= mem[req.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/background_tile_pixel_fetcher_unit.sv @@
// ---------------------------------------------------------------------------
// background_tile_pixel_fetcher_unit: background tile fetcher with 8 KiB VRAM
// Four-phase tile fetcher (tile id, low plane, high plane, ready) over an
// internal video memory loaded by write beats.
// ---------------------------------------------------------------------------
// Every request beat (restart, tick, take or memory write) gives exactly one
// response beat, in the cycle after acceptance, and a new beat is taken every
// cycle while req_stall is low. The fetcher state lives next to a single-port
// VRAM with registered read data; a byte read by a tick is forwarded straight
// into the address or pixel path of the following beat, so back-to-back ticks
// run at full rate. The response sits in an output register; req_stall rises
// only while that register holds a beat and rsp_stall is high. The VRAM has no
// clear after reset: reading a byte never written returns unknown data.
// ---------------------------------------------------------------------------
module background_tile_pixel_fetcher_unit
   import btpf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic [4:0]             req_start_column,
   input  logic [4:0]             req_start_row,
   input  logic [2:0]             req_fine_row,
   input  logic [12:0]            req_mem_address,
   input  logic [7:0]             req_mem_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_ready_res,
   output logic                   rsp_pixels_valid,
   output logic [15:0]            rsp_pixel_row
);

   function automatic logic [15:0] pack_pixels(input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] row;
      row = '0;
      for (int i = 0; i < 8; i++) begin
         row[2*i +: 2] = {hi[i], lo[i]};
      end
      return row;
   endfunction

   // configuration
   logic map_sel_ff, data_unsigned_ff;

   // fetcher state
   phase_type   phase_ff, phase_in;
   capture_type pend_ff, pend_in;
   logic [4:0]  col_ff, col_in;
   logic [4:0]  row_ff, row_in;
   logic [2:0]  fine_ff, fine_in;
   logic [11:0] plane_addr_ff, plane_addr_in;   // low-plane address, bit 0 dropped
   logic [7:0]  tile_id_ff, low_ff, high_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ready_ff, rsp_ready_in;
   logic        rsp_pix_valid_ff, rsp_pix_valid_in;
   logic [15:0] rsp_row_ff, rsp_row_in;

   vram_req_type vram_req;
   logic [7:0]   rd_data;
   logic [7:0]   eff_id, eff_low, eff_high;
   logic [12:0]  low_addr;
   logic         req_acc;
   cmd_type      cmd;

   btpf_vram u_vram (
      .clock   (clock),
      .req     (vram_req),
      .rd_data (rd_data)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_acc   = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_cmd);

   // read data of the previous beat is not in its register yet: forward it
   assign eff_id   = (pend_ff == CAP_ID)   ? rd_data : tile_id_ff;
   assign eff_low  = (pend_ff == CAP_LOW)  ? rd_data : low_ff;
   assign eff_high = (pend_ff == CAP_HIGH) ? rd_data : high_ff;

   // signed mode puts ids 0..127 at 0x1000 and 128..255 at 0x0800
   assign low_addr = {(!data_unsigned_ff && !eff_id[7]), eff_id, fine_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         map_sel_ff       <= 1'b0;
         data_unsigned_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TILE_MAP_SELECT:    map_sel_ff       <= csr_wdata;
            CSR_TILE_DATA_UNSIGNED: data_unsigned_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TILE_ID;
         pend_ff      <= CAP_NONE;
         col_ff       <= '0;
         row_ff       <= '0;
         fine_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         fine_ff      <= fine_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_id_ff <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
      end else begin
         case (pend_ff)
            CAP_ID:   tile_id_ff <= rd_data;
            CAP_LOW:  low_ff     <= rd_data;
            CAP_HIGH: high_ff    <= rd_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      plane_addr_ff <= plane_addr_in;
      if (req_acc) begin
         rsp_ready_ff     <= rsp_ready_in;
         rsp_pix_valid_ff <= rsp_pix_valid_in;
         rsp_row_ff       <= rsp_row_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      pend_in        = CAP_NONE;
      col_in         = col_ff;
      row_in         = row_ff;
      fine_in        = fine_ff;
      plane_addr_in  = plane_addr_ff;
      vram_req.en    = 1'b0;
      vram_req.we    = 1'b0;
      vram_req.addr  = req_mem_address;
      vram_req.wdata = req_mem_data;

      if (req_acc) begin
         case (cmd)
            CMD_RESTART: begin
               col_in   = req_start_column;
               row_in   = req_start_row;
               fine_in  = req_fine_row;
               phase_in = PH_TILE_ID;
            end
            CMD_TICK: begin
               case (phase_ff)
                  PH_TILE_ID: begin
                     vram_req.en   = 1'b1;
                     vram_req.addr = {MAP_BASE_TOP, map_sel_ff, row_ff, col_ff};
                     pend_in       = CAP_ID;
                     phase_in      = PH_LOW;
                  end
                  PH_LOW: begin
                     vram_req.en   = 1'b1;
                     vram_req.addr = low_addr;
                     plane_addr_in = low_addr[12:1];
                     pend_in       = CAP_LOW;
                     phase_in      = PH_HIGH;
                  end
                  PH_HIGH: begin
                     vram_req.en   = 1'b1;
                     vram_req.addr = {plane_addr_ff, 1'b1};
                     pend_in       = CAP_HIGH;
                     col_in        = col_ff + 5'd1;
                     phase_in      = PH_READY;
                  end
                  default: ;   // ready: keep waiting
               endcase
            end
            CMD_TAKE: begin
               phase_in = PH_TILE_ID;
            end
            CMD_WRITE: begin
               vram_req.en = 1'b1;
               vram_req.we = 1'b1;
            end
            default: ;
         endcase
      end

      rsp_ready_in     = (phase_in == PH_READY);
      rsp_pix_valid_in = (cmd == CMD_TAKE);
      rsp_row_in       = (cmd == CMD_TAKE) ? pack_pixels(eff_low, eff_high) : 16'd0;

      if (req_acc) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ready_res    = rsp_ready_ff;
   assign rsp_pixels_valid = rsp_pix_valid_ff;
   assign rsp_pixel_row    = rsp_row_ff;

endmodule

@@ hdl/btpf_checker.sv @@
// ---------------------------------------------------------------------------
// btpf_checker: port-level checks of the background tile pixel fetcher
// Watches the request and response channels; bound to the top level.
// ---------------------------------------------------------------------------
module btpf_checker
   import btpf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_ready_res,
   input logic        rsp_pixels_valid,
   input logic [15:0] rsp_pixel_row
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_row)
                                && $stable(rsp_pixels_valid))
      else $error("stalled response beat changed");

   // the request side only backs up behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   a_take_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_cmd == CMD_TAKE) |=> rsp_valid && rsp_pixels_valid && !rsp_ready_res)
      else $error("take beat did not give pixels");

   a_other_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_cmd != CMD_TAKE)
      |=> rsp_valid && !rsp_pixels_valid && (rsp_pixel_row == 16'd0))
      else $error("non-take beat gave pixels");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind background_tile_pixel_fetcher_unit btpf_checker u_btpf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_ready_res    (rsp_ready_res),
   .rsp_pixels_valid (rsp_pixels_valid),
   .rsp_pixel_row    (rsp_pixel_row)
);
